// ===== design/rrts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Shared types, operation codes and defaults for the scheduler and its cells.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Default depth of the task table.
    localparam int MAX_TASKS_DEF = 16;

    // Operation codes carried in a request word.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_YIELD  = 3'd1;
    localparam logic [2:0] OP_SLEEP  = 3'd2;
    localparam logic [2:0] OP_WAKEUP = 3'd3;
    localparam logic [2:0] OP_ALARM  = 3'd4;
    localparam logic [2:0] OP_EXIT   = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;
    localparam logic [2:0] OP_START  = 3'd7;

    // Status codes carried in a response word.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NO_RUN     = 2'd2;
    localparam logic [1:0] ST_NO_CURRENT = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] wait_channel;
        logic [15:0] delay;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] task_index;
        logic [7:0] task_id;
        logic       timed_out;
    } rsp_t;

    // One task table entry as held by a cell.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] chan;
        logic [15:0] alarm;
        logic        sleeping;
    } entry_t;

    // Command for one cell in one cycle.
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_ADD,
        CO_SHIFT,
        CO_SLEEP,
        CO_ALARM,
        CO_RESUME,
        CO_WAKE
    } cell_op_t;

    // Arguments broadcast to every cell.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] chan;
        logic [15:0] alarm;
        logic [15:0] tick;
    } cell_arg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_IDSCAN,
        S_SETUP,
        S_SEARCH
    } state_t;

endpackage
`default_nettype wire

// ===== design/rrts_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler table cell
// Holds one task entry, updates it on command and flags it as runnable.
// ----------------------------------------------------------------------------
module rrts_cell
    import rrts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_op_t  op,
    input  wire cell_arg_t arg,
    input  wire entry_t    upper,
    output      entry_t    entry,
    output      logic      eligible
);

    logic [7:0]  id_reg;
    logic [15:0] chan_reg;
    logic [15:0] alarm_reg;
    logic        sleeping_reg;
    entry_t      entry_next;
    logic [15:0] diff;

    // Next entry value for each command.
    always_comb
    begin
        entry_next = entry;
        unique case (op)
            CO_HOLD:   entry_next = entry;
            CO_ADD:
            begin
                entry_next.id       = arg.id;
                entry_next.chan     = '0;
                entry_next.alarm    = '0;
                entry_next.sleeping = 1'b0;
            end
            CO_SHIFT:  entry_next = upper;
            CO_SLEEP:
            begin
                entry_next.chan     = arg.chan;
                entry_next.sleeping = 1'b1;
            end
            CO_ALARM:  entry_next.alarm = arg.alarm;
            CO_RESUME:
            begin
                entry_next.chan     = '0;
                entry_next.alarm    = '0;
                entry_next.sleeping = 1'b0;
            end
            CO_WAKE:
            begin
                if (chan_reg == arg.chan)
                begin
                    entry_next.chan = '0;
                end
            end
            default:   entry_next = entry;
        endcase
    end

    // The sleeping mark is cleared by reset; the payload fields are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleeping_reg <= 1'b0;
        end
        else
        begin
            sleeping_reg <= entry_next.sleeping;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= entry_next.id;
        chan_reg  <= entry_next.chan;
        alarm_reg <= entry_next.alarm;
    end

    // Runnable when no channel is set or the alarm has fallen due.
    assign diff     = arg.tick - alarm_reg;
    assign eligible = (chan_reg == 16'd0) ||
                      ((alarm_reg != 16'd0) && !diff[15]);
    assign entry    = {id_reg, chan_reg, alarm_reg, sleeping_reg};

endmodule
`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Task table held in a row of cells, with a sequencer for add and yield.
// ----------------------------------------------------------------------------
// One request word is handled at a time and answers with one response word.
// Tick, wakeup, alarm and refused requests are answered straight from idle.
// Add tries candidate ids in turn against every live entry. Yield, sleep,
// exit and start set up a round-robin search of the table; the search reads
// one cell a cycle. A new request is taken once the previous response has
// left or is leaving the output register.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output      logic req_ready,
    input  wire req_t req,
    output      logic rsp_valid,
    input  wire logic rsp_ready,
    output      rsp_t rsp
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [7:0]         cur_id_reg, cur_id_next;
    logic [15:0]        tick_reg, tick_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic [7:0]         cand_reg, cand_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    cell_op_t           cell_op [MAX_TASKS];
    entry_t             entries [MAX_TASKS];
    logic [MAX_TASKS-1:0] elig;
    logic [MAX_TASKS-1:0] id_hit;
    cell_arg_t          arg;
    logic               accept;
    logic [15:0]        alarm_val;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   cur_inc;
    entry_t             sel;

    // Row of cells; each takes its upper neighbour's entry on a shift.
    for (genvar g = 0; g < MAX_TASKS; g++)
    begin : g_cell
        entry_t upper;
        if (g == MAX_TASKS - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = entries[g+1];
        end
        rrts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (cell_op[g]),
            .arg      (arg),
            .upper    (upper),
            .entry    (entries[g]),
            .eligible (elig[g])
        );
        assign id_hit[g] = (entries[g].id == cand_reg) && (CNT_W'(g) < count_reg);
    end

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign alarm_val = tick_reg + req.delay + 16'd1;
    assign ptr_inc   = CNT_W'(ptr_reg) + CNT_W'(1);
    assign cur_inc   = CNT_W'(cur_reg) + CNT_W'(1);
    assign sel       = entries[ptr_reg];

    // Sequencer: next state, cell commands and response.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        tick_next      = tick_reg;
        ptr_next       = ptr_reg;
        steps_next     = steps_reg;
        cand_next      = cand_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            cell_op[i] = CO_HOLD;
        end
        arg.id    = cand_reg;
        arg.chan  = req.wait_channel;
        arg.alarm = (alarm_val == 16'd0) ? 16'd1 : alarm_val;
        arg.tick  = tick_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.status     = ST_OK;
                    rsp_next.task_index = cur_valid_reg ? 4'(cur_reg) : 4'd0;
                    rsp_next.task_id    = cur_valid_reg ? cur_id_reg : 8'd0;
                    rsp_next.timed_out  = 1'b0;
                    unique case (req.operation)
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_TASKS))
                            begin
                                rsp_next.status     = ST_FULL;
                                rsp_next.task_index = 4'd0;
                                rsp_next.task_id    = 8'd0;
                                rsp_valid_next      = 1'b1;
                            end
                            else
                            begin
                                cand_next  = 8'd1;
                                state_next = S_IDSCAN;
                            end
                        end
                        OP_YIELD:
                        begin
                            state_next = S_SETUP;
                        end
                        OP_SLEEP, OP_ALARM, OP_EXIT:
                        begin
                            if (!cur_valid_reg)
                            begin
                                rsp_next.status     = ST_NO_CURRENT;
                                rsp_next.task_index = 4'd0;
                                rsp_next.task_id    = 8'd0;
                                rsp_valid_next      = 1'b1;
                            end
                            else if (req.operation == OP_SLEEP)
                            begin
                                cell_op[cur_reg] = CO_SLEEP;
                                state_next       = S_SETUP;
                            end
                            else if (req.operation == OP_ALARM)
                            begin
                                cell_op[cur_reg] = CO_ALARM;
                                rsp_valid_next   = 1'b1;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_TASKS; i++)
                                begin
                                    if (CNT_W'(i) >= CNT_W'(cur_reg))
                                    begin
                                        cell_op[i] = CO_SHIFT;
                                    end
                                end
                                count_next     = count_reg - CNT_W'(1);
                                cur_valid_next = 1'b0;
                                state_next     = S_SETUP;
                            end
                        end
                        OP_WAKEUP:
                        begin
                            for (int i = 0; i < MAX_TASKS; i++)
                            begin
                                if (CNT_W'(i) < count_reg)
                                begin
                                    cell_op[i] = CO_WAKE;
                                end
                            end
                            rsp_valid_next = 1'b1;
                        end
                        OP_TICK:
                        begin
                            tick_next      = tick_reg + 16'd1;
                            rsp_valid_next = 1'b1;
                        end
                        OP_START:
                        begin
                            cur_valid_next = 1'b0;
                            state_next     = S_SETUP;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // Try one candidate id a cycle against every live entry.
            S_IDSCAN:
            begin
                if (id_hit == '0)
                begin
                    cell_op[count_reg[IDX_W-1:0]] = CO_ADD;
                    rsp_next.status     = ST_OK;
                    rsp_next.task_index = 4'(count_reg);
                    rsp_next.task_id    = cand_reg;
                    rsp_next.timed_out  = 1'b0;
                    rsp_valid_next      = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                    state_next          = S_IDLE;
                end
                else
                begin
                    cand_next = cand_reg + 8'd1;
                end
            end

            // Start the search after the current task, or at entry zero.
            S_SETUP:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status     = ST_NO_RUN;
                    rsp_next.task_index = 4'd0;
                    rsp_next.task_id    = 8'd0;
                    rsp_next.timed_out  = 1'b0;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    if (cur_valid_reg && (cur_inc != count_reg))
                    begin
                        ptr_next = cur_inc[IDX_W-1:0];
                    end
                    else
                    begin
                        ptr_next = '0;
                    end
                    steps_next = count_reg;
                    state_next = S_SEARCH;
                end
            end

            // Visit one entry a cycle in round-robin order.
            S_SEARCH:
            begin
                if (elig[ptr_reg])
                begin
                    if (sel.sleeping)
                    begin
                        cell_op[ptr_reg] = CO_RESUME;
                    end
                    cur_next            = ptr_reg;
                    cur_valid_next      = 1'b1;
                    cur_id_next         = sel.id;
                    rsp_next.status     = ST_OK;
                    rsp_next.task_index = 4'(ptr_reg);
                    rsp_next.task_id    = sel.id;
                    rsp_next.timed_out  = sel.sleeping && (sel.chan != 16'd0);
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (steps_reg == CNT_W'(1))
                begin
                    rsp_next.status     = ST_NO_RUN;
                    rsp_next.task_index = 4'd0;
                    rsp_next.task_id    = 8'd0;
                    rsp_next.timed_out  = 1'b0;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    ptr_next   = (ptr_inc == count_reg) ? '0 : ptr_inc[IDX_W-1:0];
                    steps_next = steps_reg - CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            tick_reg      <= tick_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working registers and the response word.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        cur_id_reg <= cur_id_next;
        ptr_reg    <= ptr_next;
        steps_reg  <= steps_next;
        cand_reg   <= cand_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ===== tb/sv/round_robin_task_scheduler_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin task scheduler testbench
// Drives request words through a valid/ready channel, predicts each response
// word with an independent model of the task table, and compares in order.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_test;
    import rrts_pkg::*;

    localparam int NTASK = MAX_TASKS_DEF;
    localparam int NONE_IDX = 31;
    localparam int WATCHDOG_LIMIT = 2000;

    // Task table predictor with its own copy of the scheduler state.
    class sched_scoreboard;
        logic [7:0]  ids [NTASK];
        logic [15:0] chans [NTASK];
        logic [15:0] alarms [NTASK];
        bit          sleepers [NTASK];
        int          count;
        int          cur;
        logic [15:0] ticks;
        rsp_t        pending [$];
        int          errors;

        function new();
            count = 0;
            cur = NONE_IDX;
            ticks = 0;
            errors = 0;
            for (int i = 0; i < NTASK; i++)
            begin
                ids[i] = 0;
                chans[i] = 0;
                alarms[i] = 0;
                sleepers[i] = 0;
            end
        endfunction

        function bit running();
            return cur != NONE_IDX && cur < count;
        endfunction

        function rsp_t make(logic [1:0] st, int idx, logic [7:0] id, bit to);
            rsp_t r;
            r.status = st;
            r.task_index = idx[3:0];
            r.task_id = id;
            r.timed_out = to;
            return r;
        endfunction

        function rsp_t current_word();
            if (running())
                return make(ST_OK, cur, ids[cur], 1'b0);
            return make(ST_OK, 0, 8'd0, 1'b0);
        endfunction

        // Round-robin search for a runnable or alarm-due task.
        function rsp_t pick_next();
            int first;
            int idx;
            bit to;
            logic [15:0] diff;
            if (count == 0)
                return make(ST_NO_RUN, 0, 8'd0, 1'b0);
            first = running() ? cur : count - 1;
            for (int k = 1; k <= count; k++)
            begin
                idx = (first + k) % count;
                diff = ticks - alarms[idx];
                if (chans[idx] == 0 || (alarms[idx] != 0 && !diff[15]))
                begin
                    cur = idx;
                    to = 1'b0;
                    if (sleepers[idx])
                    begin
                        sleepers[idx] = 0;
                        alarms[idx] = 0;
                        to = chans[idx] != 0;
                        chans[idx] = 0;
                    end
                    return make(ST_OK, idx, ids[idx], to);
                end
            end
            return make(ST_NO_RUN, 0, 8'd0, 1'b0);
        endfunction

        function rsp_t add_task();
            int id;
            bit used;
            rsp_t r;
            if (count >= NTASK)
                return make(ST_FULL, 0, 8'd0, 1'b0);
            for (id = 1; id < 256; id++)
            begin
                used = 0;
                for (int t = 0; t < count; t++)
                    if (ids[t] == id[7:0])
                        used = 1;
                if (!used)
                    break;
            end
            ids[count] = id[7:0];
            chans[count] = 0;
            alarms[count] = 0;
            sleepers[count] = 0;
            r = make(ST_OK, count, id[7:0], 1'b0);
            count++;
            return r;
        endfunction

        // Notes an accepted request word and queues its expected response.
        function void note_request(req_t q);
            rsp_t r;
            logic [15:0] a;
            case (q.operation)
                OP_ADD: r = add_task();
                OP_YIELD: r = pick_next();
                OP_SLEEP:
                    if (!running())
                        r = make(ST_NO_CURRENT, 0, 8'd0, 1'b0);
                    else
                    begin
                        chans[cur] = q.wait_channel;
                        sleepers[cur] = 1;
                        r = pick_next();
                    end
                OP_WAKEUP:
                begin
                    for (int i = 0; i < count; i++)
                        if (chans[i] == q.wait_channel)
                            chans[i] = 0;
                    r = current_word();
                end
                OP_ALARM:
                    if (!running())
                        r = make(ST_NO_CURRENT, 0, 8'd0, 1'b0);
                    else
                    begin
                        a = ticks + q.delay + 16'd1;
                        if (a == 0)
                            a = 16'd1;
                        alarms[cur] = a;
                        r = current_word();
                    end
                OP_EXIT:
                    if (!running())
                        r = make(ST_NO_CURRENT, 0, 8'd0, 1'b0);
                    else
                    begin
                        count--;
                        for (int i = cur; i < count; i++)
                        begin
                            ids[i] = ids[i + 1];
                            chans[i] = chans[i + 1];
                            alarms[i] = alarms[i + 1];
                            sleepers[i] = sleepers[i + 1];
                        end
                        sleepers[count] = 0;
                        cur = NONE_IDX;
                        r = pick_next();
                    end
                OP_TICK:
                begin
                    ticks = ticks + 16'd1;
                    r = current_word();
                end
                default:
                begin
                    cur = NONE_IDX;
                    r = pick_next();
                end
            endcase
            pending.push_back(r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        // Checks one accepted response word against the oldest expectation.
        task check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report("unexpected response word", 16'(got), 16'd0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report("status", 16'(got.status), 16'(want.status));
            if (got.task_index !== want.task_index)
                report("task_index", 16'(got.task_index), 16'(want.task_index));
            if (got.task_id !== want.task_id)
                report("task_id", 16'(got.task_id), 16'(want.task_id));
            if (got.timed_out !== want.timed_out)
                report("timed_out", 16'(got.timed_out), 16'(want.timed_out));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    sched_scoreboard sb;
    bit calm;
    bit sender_done;
    int idle_cycles;

    round_robin_task_scheduler dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sends one request word, with an occasional burst of idle cycles first.
    // Valid stays high straight into the next word when there is no gap.
    task automatic send_word(logic [2:0] op, logic [15:0] ch, logic [15:0] dl);
        req_t q;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        q.operation = op;
        q.wait_channel = ch;
        q.delay = dl;
        req <= q;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(q);
    endtask

    // Drops valid and waits until every expected response has come back.
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Small channel set so that wakeups often match sleepers.
    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 6));
        endcase
    endfunction

    // Operation mix leans towards scheduling with a modest table size.
    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return OP_ADD;
        if (r < 30) return OP_YIELD;
        if (r < 46) return OP_SLEEP;
        if (r < 58) return OP_WAKEUP;
        if (r < 68) return OP_ALARM;
        if (r < 78) return OP_EXIT;
        if (r < 94) return OP_TICK;
        return OP_START;
    endfunction

    // Receiver side: stalls in bursts, accepts and checks response words.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 15))
                begin
                    @(posedge clk);
                end
            end
            rsp_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted word.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else if (!sender_done)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then random words, then drain.
    initial
    begin
        int waited;
        sb = new();
        calm = 0;
        sender_done = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table and no current task.
        send_word(OP_YIELD, 16'd0, 16'd0);
        send_word(OP_SLEEP, 16'd1, 16'd0);
        send_word(OP_ALARM, 16'd0, 16'd5);
        send_word(OP_EXIT, 16'd0, 16'd0);
        send_word(OP_WAKEUP, 16'hFFFF, 16'd0);
        send_word(OP_TICK, 16'd0, 16'd0);
        // Fill the table, then one add beyond full.
        repeat (NTASK + 1) send_word(OP_ADD, 16'd0, 16'd0);
        send_word(OP_START, 16'd0, 16'd0);
        send_word(OP_ALARM, 16'd0, 16'hFFFF);
        send_word(OP_SLEEP, 16'hFFFF, 16'hFFFF);
        send_word(OP_SLEEP, 16'd0, 16'd0);
        send_word(OP_EXIT, 16'd0, 16'd0);

        // Wait for every expected response before the random part.
        drain_responses();

        for (int n = 0; n < 1000; n++)
        begin
            if (n == 400)
                drain_responses();
            if (n == 850)
                calm = 1;
            // Keep the table small most of the time, draining it now and then.
            if (sb.count > 8 && $urandom_range(0, 1) == 0)
                send_word(OP_EXIT, pick_channel(), pick_delay());
            else
                send_word(pick_op(), pick_channel(), pick_delay());
        end
        req_valid <= 1'b0;
        sender_done = 1;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (NTASK + 20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
